### design/interval_coverage_accumulator_assert.svh
// Assertion macros for the interval coverage accumulator.
`ifndef INTERVAL_COVERAGE_ACCUMULATOR_ASSERT_SVH
`define INTERVAL_COVERAGE_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define ICA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("interval_coverage_accumulator: assertion failed");

// next-cycle implication
`define ICA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("interval_coverage_accumulator: assertion failed");

`endif

### design/ica_pkg.sv
// Shared constants and types of the interval coverage accumulator.
`default_nettype none
package ica_pkg;

	localparam int unsigned POSITIONS_DEF   = 65536;
	localparam int unsigned COUNT_WIDTH_DEF = 16;
	localparam int unsigned POS_W           = 17;
	localparam int unsigned MEAN_W          = 24;
	localparam int unsigned MEAN_FRAC       = 8;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_WALK  = 5'b00100,
		S_DIV   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

endpackage
`default_nettype wire

### design/ica_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ica_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### design/interval_coverage_accumulator.sv
// Interval coverage accumulator: saturating per-position coverage and mean queries.
//
//   channel | direction | word
//   in      | sink      | action, ref_start, ref_end, query_start, query_end
//   out     | source    | status, ref_mean, query_mean
//
// After reset a clearing pass writes zeros to every position of both stores; no words are taken.
// Both stores are walked in parallel at one position per cycle (read, then write back on add or sum on query).
// Add: the walk writes back, then the result is loaded; query: the walk sums the counts, then the
// restoring divide yields both means; a flagged word skips the walk. The next word is taken the cycle
// after a result is loaded; a second result stalls in S_DONE while out_ready is low.
`default_nettype none
`include "interval_coverage_accumulator_assert.svh"
module interval_coverage_accumulator #(
	parameter int unsigned POSITIONS   = ica_pkg::POSITIONS_DEF,
	parameter int unsigned COUNT_WIDTH = ica_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        action,
	input  wire logic [ica_pkg::POS_W-1:0]   ref_start,
	input  wire logic [ica_pkg::POS_W-1:0]   ref_end,
	input  wire logic [ica_pkg::POS_W-1:0]   query_start,
	input  wire logic [ica_pkg::POS_W-1:0]   query_end,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             status,
	output logic      [ica_pkg::MEAN_W-1:0]  ref_mean,
	output logic      [ica_pkg::MEAN_W-1:0]  query_mean
);
	import ica_pkg::*;

	localparam int unsigned AW  = $clog2(POSITIONS);
	localparam int unsigned SW  = COUNT_WIDTH + POS_W;
	localparam int unsigned DW  = SW + MEAN_FRAC;
	localparam int unsigned DCW = $clog2(DW);
	localparam logic [AW-1:0]  CLR_LAST = AW'(POSITIONS - 1);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(DW - 1);

	function automatic logic pos_ok(input logic [POS_W-1:0] p);
		return (p != '0) && (32'(p) <= POSITIONS);
	endfunction

	function automatic logic [AW-1:0] to_addr(input logic [POS_W-1:0] p);
		logic [POS_W-1:0] pm;
		pm = p - 1'b1;
		return AW'(pm);
	endfunction

	function automatic logic [MEAN_W-1:0] sat_mean(input logic [DW-1:0] q);
		return (|q[DW-1:MEAN_W]) ? '1 : q[MEAN_W-1:0];
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	state_t state_q;
	logic [AW-1:0]  clr_q;
	logic           act_q, bad_q;
	logic [AW-1:0]  r_addr_q, r_hi_q, q_addr_q, q_hi_q;
	logic           r_go_q, q_go_q;
	logic           r_vld_s1, q_vld_s1;
	logic [AW-1:0]  r_addr_s1, q_addr_s1;
	logic [POS_W-1:0] r_n_q, q_n_q;
	logic [SW-1:0]  r_sum_q, q_sum_q;
	logic [DW-1:0]  r_quo_q, q_quo_q;
	logic [POS_W-1:0] r_rem_q, q_rem_q;
	logic [DCW-1:0] div_cnt_q;
	logic           out_valid_q, status_q;
	logic [MEAN_W-1:0] ref_mean_q, query_mean_q;

	logic [POS_W-1:0] q_lo_f, q_hi_f;
	logic           in_bad, accept, walk_done, load_out;
	logic           r_we, q_we;
	logic [AW-1:0]  r_waddr, q_waddr;
	logic [COUNT_WIDTH-1:0] r_wdata, q_wdata, r_rdata, q_rdata;
	logic [POS_W:0] r_shift, q_shift, r_diff, q_diff;
	logic           r_ge, q_ge;

	assign q_lo_f = (query_start < query_end) ? query_start : query_end;
	assign q_hi_f = (query_start < query_end) ? query_end : query_start;
	assign in_bad = !pos_ok(ref_start) || !pos_ok(ref_end) || !pos_ok(query_start)
		|| !pos_ok(query_end) || (ref_start > ref_end);

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign walk_done = (state_q == S_WALK) && !r_go_q && !q_go_q && !r_vld_s1 && !q_vld_s1;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		if (state_q == S_CLEAR) begin
			r_we    = 1'b1;
			q_we    = 1'b1;
			r_waddr = clr_q;
			q_waddr = clr_q;
			r_wdata = '0;
			q_wdata = '0;
		end else begin
			r_we    = r_vld_s1 && !act_q;
			q_we    = q_vld_s1 && !act_q;
			r_waddr = r_addr_s1;
			q_waddr = q_addr_s1;
			r_wdata = sat_inc(r_rdata);
			q_wdata = sat_inc(q_rdata);
		end
	end

	ica_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(POSITIONS)) u_ref_ram (
		.clk  (clk),
		.we   (r_we),
		.waddr(r_waddr),
		.wdata(r_wdata),
		.raddr(r_addr_q),
		.rdata(r_rdata)
	);

	ica_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(POSITIONS)) u_query_ram (
		.clk  (clk),
		.we   (q_we),
		.waddr(q_waddr),
		.wdata(q_wdata),
		.raddr(q_addr_q),
		.rdata(q_rdata)
	);

	// restoring divide, one quotient bit per cycle
	always_comb begin
		r_shift = {r_rem_q, r_quo_q[DW-1]};
		q_shift = {q_rem_q, q_quo_q[DW-1]};
		r_ge    = r_shift >= {1'b0, r_n_q};
		q_ge    = q_shift >= {1'b0, q_n_q};
		r_diff  = r_shift - {1'b0, r_n_q};
		q_diff  = q_shift - {1'b0, q_n_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			r_go_q      <= 1'b0;
			q_go_q      <= 1'b0;
			r_vld_s1    <= 1'b0;
			q_vld_s1    <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			r_vld_s1 <= (state_q == S_WALK) && r_go_q;
			q_vld_s1 <= (state_q == S_WALK) && q_go_q;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= in_bad ? S_DONE : S_WALK;
						r_go_q  <= !in_bad;
						q_go_q  <= !in_bad;
					end
				end
				S_WALK: begin
					if (r_go_q && (r_addr_q == r_hi_q)) begin
						r_go_q <= 1'b0;
					end
					if (q_go_q && (q_addr_q == q_hi_q)) begin
						q_go_q <= 1'b0;
					end
					if (walk_done) begin
						state_q   <= act_q ? S_DIV : S_DONE;
						div_cnt_q <= '0;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action;
			bad_q    <= in_bad;
			r_addr_q <= to_addr(ref_start);
			r_hi_q   <= to_addr(ref_end);
			q_addr_q <= to_addr(q_lo_f);
			q_hi_q   <= to_addr(q_hi_f);
			r_n_q    <= ref_end - ref_start + 1'b1;
			q_n_q    <= q_hi_f - q_lo_f + 1'b1;
			r_sum_q  <= '0;
			q_sum_q  <= '0;
		end
		if (state_q == S_WALK) begin
			if (r_go_q) begin
				r_addr_q <= r_addr_q + 1'b1;
			end
			if (q_go_q) begin
				q_addr_q <= q_addr_q + 1'b1;
			end
		end
		r_addr_s1 <= r_addr_q;
		q_addr_s1 <= q_addr_q;
		if (r_vld_s1 && act_q) begin
			r_sum_q <= r_sum_q + SW'(r_rdata);
		end
		if (q_vld_s1 && act_q) begin
			q_sum_q <= q_sum_q + SW'(q_rdata);
		end
		if (walk_done) begin
			r_quo_q <= {r_sum_q, {MEAN_FRAC{1'b0}}};
			q_quo_q <= {q_sum_q, {MEAN_FRAC{1'b0}}};
			r_rem_q <= '0;
			q_rem_q <= '0;
		end else if (state_q == S_DIV) begin
			r_rem_q <= r_ge ? r_diff[POS_W-1:0] : r_shift[POS_W-1:0];
			q_rem_q <= q_ge ? q_diff[POS_W-1:0] : q_shift[POS_W-1:0];
			r_quo_q <= {r_quo_q[DW-2:0], r_ge};
			q_quo_q <= {q_quo_q[DW-2:0], q_ge};
		end
		if (load_out) begin
			status_q     <= bad_q;
			ref_mean_q   <= (act_q && !bad_q) ? sat_mean(r_quo_q) : '0;
			query_mean_q <= (act_q && !bad_q) ? sat_mean(q_quo_q) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign ref_mean   = ref_mean_q;
	assign query_mean = query_mean_q;

	`ICA_ASSERT_IMP(a_no_word_in_clear, (state_q == S_CLEAR), !in_ready)
	`ICA_ASSERT_IMP(a_no_write_on_query, ((state_q == S_WALK) && act_q), (!r_we && !q_we))
	`ICA_ASSERT_NXT(a_result_held, ((state_q == S_DONE) && out_valid_q && !out_ready), (state_q == S_DONE))
	`ICA_ASSERT_IMP(a_flagged_zero, (out_valid && status), ((ref_mean == '0) && (query_mean == '0)))

endmodule
`default_nettype wire

### dv/tb_interval_coverage_accumulator.sv
// Self-checking testbench for the interval coverage accumulator: directed table, then random words.
module tb_interval_coverage_accumulator;
	import ica_pkg::*;

	localparam int POS_COUNT = POSITIONS_DEF;
	localparam int COUNT_W = COUNT_WIDTH_DEF;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;
	localparam longint unsigned MEAN_LIMIT = (64'd1 << MEAN_W) - 1;
	localparam int DIR_ROWS = 22;
	localparam int RAND_PHASES = 8;
	localparam int RAND_PER_PHASE = 225;
	localparam int DRAIN_CYCLES = 256;
	localparam int MAX_PRINTS = 100;

	localparam logic ACT_ADD = 1'b0;
	localparam logic ACT_QUERY = 1'b1;
	localparam logic ST_OK = 1'b0;
	localparam logic ST_BAD = 1'b1;
	localparam logic TYPED = 1'b1;
	localparam logic PREDICT = 1'b0;

	typedef enum {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_t;

	typedef struct packed {
		logic act;
		logic [POS_W-1:0] rs;
		logic [POS_W-1:0] re;
		logic [POS_W-1:0] qa;
		logic [POS_W-1:0] qb;
	} word_t;

	typedef struct packed {
		logic st;
		logic [MEAN_W-1:0] rm;
		logic [MEAN_W-1:0] qm;
	} result_t;

	typedef struct {
		logic act;
		int rs;
		int re;
		int qa;
		int qb;
		logic typed;
		logic st;
		int rm;
		int qm;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic action;
	logic [POS_W-1:0] ref_start;
	logic [POS_W-1:0] ref_end;
	logic [POS_W-1:0] query_start;
	logic [POS_W-1:0] query_end;
	logic out_valid;
	logic out_ready;
	logic status;
	logic [MEAN_W-1:0] ref_mean;
	logic [MEAN_W-1:0] query_mean;

	logic [COUNT_W-1:0] ref_cnt [POS_COUNT];
	logic [COUNT_W-1:0] query_cnt [POS_COUNT];
	result_t expected_results [$];
	result_t oldest_result;
	dir_row_t dir_rows [DIR_ROWS];
	gap_t idle_mode = GAP_NONE;
	int mismatch_count = 0;

	interval_coverage_accumulator #(
		.POSITIONS(POSITIONS_DEF),
		.COUNT_WIDTH(COUNT_WIDTH_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.ref_start(ref_start),
		.ref_end(ref_end),
		.query_start(query_start),
		.query_end(query_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.ref_mean(ref_mean),
		.query_mean(query_mean)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#400000000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(string msg);
		if (mismatch_count < MAX_PRINTS)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic bit pos_ok(logic [POS_W-1:0] p);
		return p >= 1 && p <= POS_COUNT;
	endfunction

	function automatic void bump_span(bit on_query, int lo, int hi);
		for (int p = lo; p <= hi; p++) begin
			if (on_query) begin
				if (query_cnt[p-1] != COUNT_LIMIT)
					query_cnt[p-1] = query_cnt[p-1] + 1'b1;
			end else begin
				if (ref_cnt[p-1] != COUNT_LIMIT)
					ref_cnt[p-1] = ref_cnt[p-1] + 1'b1;
			end
		end
	endfunction

	// floor(sum * 256 / positions), clipped to the mean width
	function automatic logic [MEAN_W-1:0] span_mean(bit on_query, int lo, int hi);
		longint unsigned total;
		longint unsigned scaled;
		total = 0;
		for (int p = lo; p <= hi; p++)
			total += on_query ? 64'(query_cnt[p-1]) : 64'(ref_cnt[p-1]);
		scaled = (total << MEAN_FRAC) / longint'(hi - lo + 1);
		return (scaled > MEAN_LIMIT) ? MEAN_LIMIT[MEAN_W-1:0] : scaled[MEAN_W-1:0];
	endfunction

	function automatic result_t predict_word(word_t w);
		result_t r;
		logic [POS_W-1:0] qlo;
		logic [POS_W-1:0] qhi;
		qlo = (w.qa < w.qb) ? w.qa : w.qb;
		qhi = (w.qa < w.qb) ? w.qb : w.qa;
		r = '0;
		r.st = ST_OK;
		if (!pos_ok(w.rs) || !pos_ok(w.re) || !pos_ok(w.qa) || !pos_ok(w.qb) || w.rs > w.re)
			r.st = ST_BAD;
		else if (w.act == ACT_ADD) begin
			bump_span(1'b0, int'(w.rs), int'(w.re));
			bump_span(1'b1, int'(qlo), int'(qhi));
		end else begin
			r.rm = span_mean(1'b0, int'(w.rs), int'(w.re));
			r.qm = span_mean(1'b1, int'(qlo), int'(qhi));
		end
		return r;
	endfunction

	// spans sit in one of three 2048-position windows so that queries land on coverage
	function automatic void rand_span(output logic [POS_W-1:0] lo, output logic [POS_W-1:0] hi);
		int base;
		int len;
		case ($urandom_range(2))
			0: base = 1;
			1: base = 20000;
			default: base = POS_COUNT - 2047;
		endcase
		len = ($urandom_range(99) < 92) ? $urandom_range(1, 32) : $urandom_range(1, 2048);
		lo = POS_W'(base + $urandom_range(0, 2048 - len));
		hi = POS_W'(lo + len - 1);
	endfunction

	function automatic word_t gen_word();
		word_t w;
		int pick;
		logic [POS_W-1:0] tmp;
		pick = $urandom_range(99);
		if (pick < 8) begin
			w.act = 1'($urandom_range(1));
			w.rs = POS_W'($urandom());
			w.re = POS_W'($urandom());
			w.qa = POS_W'($urandom());
			w.qb = POS_W'($urandom());
		end else begin
			w.act = ($urandom_range(99) < 55) ? ACT_ADD : ACT_QUERY;
			rand_span(w.rs, w.re);
			rand_span(w.qa, w.qb);
			if ($urandom_range(1)) begin
				tmp = w.qa;
				w.qa = w.qb;
				w.qb = tmp;
			end
			if (pick < 16) begin
				case ($urandom_range(4))
					0: w.rs = w.re + 1'b1;
					1: w.rs = '0;
					2: w.re = POS_W'(POS_COUNT + 1 + $urandom_range(0, POS_COUNT - 2));
					3: w.qa = '0;
					default: w.qb = POS_W'(POS_COUNT + 1 + $urandom_range(0, POS_COUNT - 2));
				endcase
			end
		end
		return w;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(word_t w, logic typed, result_t typed_res);
		result_t predicted;
		int gap_pct;
		gap_pct = (idle_mode == GAP_SEND) ? 45 : (idle_mode == GAP_BOTH) ? 28 : 0;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= w.act;
		ref_start <= w.rs;
		ref_end <= w.re;
		query_start <= w.qa;
		query_end <= w.qb;
		do @(posedge clk); while (!in_ready);
		predicted = predict_word(w);
		expected_results.insert(expected_results.size(), typed ? typed_res : predicted);
		@(negedge clk);
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			case (idle_mode)
				GAP_RECV: out_ready <= ($urandom_range(99) >= 45);
				GAP_BOTH: out_ready <= ($urandom_range(99) >= 28);
				default: out_ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0)
				report_mismatch("result word with nothing pending");
			else begin
				oldest_result = expected_results.pop_front();
				if (status !== oldest_result.st)
					report_mismatch($sformatf("status %0b, want %0b", status, oldest_result.st));
				if (ref_mean !== oldest_result.rm)
					report_mismatch($sformatf("ref_mean %h, want %h", ref_mean, oldest_result.rm));
				if (query_mean !== oldest_result.qm)
					report_mismatch($sformatf("query_mean %h, want %h", query_mean,
						oldest_result.qm));
			end
		end
	end

	initial begin
		word_t w;
		result_t fixed;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_ADD;
		ref_start = '0;
		ref_end = '0;
		query_start = '0;
		query_end = '0;
		foreach (ref_cnt[i]) begin
			ref_cnt[i] = '0;
			query_cnt[i] = '0;
		end

		dir_rows = '{
			// zero coverage after reset, both ends of the store
			'{ACT_QUERY, 1, 1, 1, 1, TYPED, ST_OK, 0, 0},
			'{ACT_QUERY, 65536, 65536, 65536, 65536, TYPED, ST_OK, 0, 0},
			// whole store once, query on reverse strand
			'{ACT_ADD, 1, 65536, 65536, 1, TYPED, ST_OK, 0, 0},
			'{ACT_QUERY, 1, 65536, 1, 65536, TYPED, ST_OK, 256, 256},
			// flagged words: zero, beyond store, reversed reference
			'{ACT_ADD, 0, 5, 1, 1, TYPED, ST_BAD, 0, 0},
			'{ACT_ADD, 1, 65537, 1, 1, TYPED, ST_BAD, 0, 0},
			'{ACT_ADD, 1, 1, 0, 1, TYPED, ST_BAD, 0, 0},
			'{ACT_ADD, 1, 1, 1, 131071, TYPED, ST_BAD, 0, 0},
			'{ACT_QUERY, 6, 5, 1, 1, TYPED, ST_BAD, 0, 0},
			'{ACT_QUERY, 131071, 131071, 131071, 131071, TYPED, ST_BAD, 0, 0},
			'{ACT_ADD, 5, 4, 3, 3, TYPED, ST_BAD, 0, 0},
			// flagged adds left the stores alone
			'{ACT_QUERY, 1, 1, 1, 1, TYPED, ST_OK, 256, 256},
			// equal query ends
			'{ACT_ADD, 10, 20, 7, 7, PREDICT, ST_OK, 0, 0},
			'{ACT_QUERY, 10, 20, 7, 7, PREDICT, ST_OK, 0, 0},
			// reverse strand
			'{ACT_ADD, 100, 100, 300, 200, PREDICT, ST_OK, 0, 0},
			'{ACT_QUERY, 99, 101, 250, 100, PREDICT, ST_OK, 0, 0},
			// top of the store
			'{ACT_ADD, 65530, 65536, 65536, 65536, PREDICT, ST_OK, 0, 0},
			'{ACT_QUERY, 65529, 65536, 65536, 65535, PREDICT, ST_OK, 0, 0},
			// fractional means
			'{ACT_ADD, 1, 3, 2, 4, PREDICT, ST_OK, 0, 0},
			'{ACT_QUERY, 1, 4, 4, 1, PREDICT, ST_OK, 0, 0},
			'{ACT_QUERY, 65536, 65536, 1, 1, PREDICT, ST_OK, 0, 0},
			'{ACT_ADD, 65536, 65536, 65536, 65536, PREDICT, ST_OK, 0, 0}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			w = '{dir_rows[i].act, POS_W'(dir_rows[i].rs), POS_W'(dir_rows[i].re),
				POS_W'(dir_rows[i].qa), POS_W'(dir_rows[i].qb)};
			fixed = '{dir_rows[i].st, MEAN_W'(dir_rows[i].rm), MEAN_W'(dir_rows[i].qm)};
			send_word(w, dir_rows[i].typed, fixed);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			idle_mode = gap_t'(ph % 4);
			repeat (RAND_PER_PHASE)
				send_word(gen_word(), PREDICT, '0);
		end

		in_valid <= 1'b0;
		idle_mode = GAP_NONE;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
